// ===== rtl/core/depth_pixel_backprojection_unit_macros.svh =====
// assertion helpers, sampled on clk and quiet while rst is high
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH

// consequence checked in the same cycle
`define DPBU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpbu check failed");

// consequence checked in the next cycle
`define DPBU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpbu check failed");

`endif

// ===== rtl/core/dpbu_pkg.sv =====
package dpbu_pkg;

  localparam int SUBSAMPLE_STEP = 2;

  localparam int POS_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int CENTER_W   = 16;
  localparam int INV_W      = 24;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int COORD_W    = 32;
  localparam int MAG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 120;

  // shared multiplier: 32 x 24
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int PART_W  = 48;
  localparam int SUM_W   = PART_W + INV_W;
  localparam int MAGN_W  = SUM_W - 28;

  localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH     = 13'd640;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT    = 13'd480;
  localparam logic [CENTER_W-1:0] RST_CENTER_X        = 16'd5208;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y        = 16'd4056;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL_X     = 24'd32388;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y     = 24'd32388;
  localparam logic [INV_W-1:0]    RST_INV_DEPTH_SCALE = 24'd16777;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_CENTER_X        = 3'd2,
    REG_CENTER_Y        = 3'd3,
    REG_INV_FOCAL_X     = 3'd4,
    REG_INV_FOCAL_Y     = 3'd5,
    REG_INV_DEPTH_SCALE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   image_width;
    logic [SIZE_W-1:0]   image_height;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
    logic [INV_W-1:0]    inv_depth_scale;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_Z  = 3'd0,
    MUL_PX = 3'd1,
    MUL_XH = 3'd2,
    MUL_XL = 3'd3,
    MUL_PY = 3'd4,
    MUL_YH = 3'd5,
    MUL_YL = 3'd6
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     cap_z;
    logic     cap_p;
    logic     cap_acc;
    logic     cap_x;
    logic     cap_y;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic keep;
  } sts_t;

  // apply sign to a truncated magnitude and clamp to signed 32 bits
  function automatic logic [COORD_W-1:0] coord_sat(input logic [MAGN_W-1:0] r,
                                                   input logic neg);
    logic [COORD_W-1:0] res;
    if (neg) begin
      if (r > MAGN_W'(64'h8000_0000)) res = 32'h8000_0000;
      else res = 32'd0 - r[COORD_W-1:0];
    end else begin
      if (r > MAGN_W'(64'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
      else res = r[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/dpbu_cfg.sv =====
module dpbu_cfg
  import dpbu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= RST_IMAGE_WIDTH;
      cfg.image_height    <= RST_IMAGE_HEIGHT;
      cfg.center_x        <= RST_CENTER_X;
      cfg.center_y        <= RST_CENTER_Y;
      cfg.inv_focal_x     <= RST_INV_FOCAL_X;
      cfg.inv_focal_y     <= RST_INV_FOCAL_Y;
      cfg.inv_depth_scale <= RST_INV_DEPTH_SCALE;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data[SIZE_W-1:0];
        REG_CENTER_X:        cfg.center_x        <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:        cfg.center_y        <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X:     cfg.inv_focal_x     <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y:     cfg.inv_focal_y     <= cfg_data[INV_W-1:0];
        REG_INV_DEPTH_SCALE: cfg.inv_depth_scale <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/dpbu_ctrl.sv =====
module dpbu_ctrl
  import dpbu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MZ   = 10'b0000000010,
    S_MPX  = 10'b0000000100,
    S_MXH  = 10'b0000001000,
    S_MXL  = 10'b0000010000,
    S_MPY  = 10'b0000100000,
    S_MYH  = 10'b0001000000,
    S_MYL  = 10'b0010000000,
    S_YFIN = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   load_out;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.accept   = accept;
    cmd.load_out = load_out;
    cmd.mul_sel  = MUL_Z;
    case (state)
      S_IDLE: begin
        if (accept && sts.keep) state_next = S_MZ;
      end
      S_MZ: begin
        cmd.mul_en = 1'b1;
        state_next = S_MPX;
      end
      S_MPX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PX;
        cmd.cap_z   = 1'b1;
        state_next  = S_MXH;
      end
      S_MXH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_XH;
        cmd.cap_p   = 1'b1;
        state_next  = S_MXL;
      end
      S_MXL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_XL;
        cmd.cap_acc = 1'b1;
        state_next  = S_MPY;
      end
      S_MPY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PY;
        cmd.cap_x   = 1'b1;
        state_next  = S_MYH;
      end
      S_MYH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_YH;
        cmd.cap_p   = 1'b1;
        state_next  = S_MYL;
      end
      S_MYL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_YL;
        cmd.cap_acc = 1'b1;
        state_next  = S_YFIN;
      end
      S_YFIN: begin
        cmd.cap_y  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/dpbu_dp.sv =====
module dpbu_dp
  import dpbu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [IN_TDATA_W-1:0]  in_data,
  output logic [OUT_TDATA_W-1:0] out_data
);

  logic [POS_W-1:0]    col, row;
  logic [DEPTH_W-1:0]  depth_q;
  logic [COLOR_W-1:0]  blue_q, green_q, red_q;
  logic [MAG_W-1:0]    magx, magy;
  logic                negx, negy;
  logic [MUL_P_W-1:0]  prod;
  logic [COORD_W-1:0]  z;
  logic [PART_W-1:0]   p;
  logic [PART_W-1:0]   acc;
  logic [COORD_W-1:0]  x_q, y_q;

  logic [DEPTH_W-1:0]  in_depth;
  logic [MAG_W:0]      dx, dy, dxn, dyn;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [SUM_W-1:0]    sum;
  logic [MAGN_W-1:0]   sum_r;
  logic                col_wrap, row_wrap;

  assign in_depth = in_data[DEPTH_W-1:0];

  assign sts.keep = ((col % SUBSAMPLE_STEP) == 0) && ((row % SUBSAMPLE_STEP) == 0)
                    && (in_depth != '0);

  // pixel offset from the principal point, 4 fraction bits
  assign dx  = {1'b0, col, 4'b0} - {1'b0, cfg.center_x};
  assign dy  = {1'b0, row, 4'b0} - {1'b0, cfg.center_y};
  assign dxn = (MAG_W+1)'(0) - dx;
  assign dyn = (MAG_W+1)'(0) - dy;

  assign col_wrap = (({1'b0, col} + SIZE_W'(1)) >= cfg.image_width) || (&col);
  assign row_wrap = (({1'b0, row} + SIZE_W'(1)) >= cfg.image_height) || (&row);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + POS_W'(1);
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      depth_q <= in_depth;
      blue_q  <= in_data[DEPTH_W +: COLOR_W];
      green_q <= in_data[DEPTH_W+COLOR_W +: COLOR_W];
      red_q   <= in_data[DEPTH_W+2*COLOR_W +: COLOR_W];
      negx    <= dx[MAG_W];
      negy    <= dy[MAG_W];
      magx    <= dx[MAG_W] ? dxn[MAG_W-1:0] : dx[MAG_W-1:0];
      magy    <= dy[MAG_W] ? dyn[MAG_W-1:0] : dy[MAG_W-1:0];
    end
  end

  // operand select for the shared multiplier; the 48-bit partial product
  // times the inverse is split into high and low 24-bit halves
  always_comb begin
    case (cmd.mul_sel)
      MUL_Z: begin
        mul_a = {16'b0, depth_q};
        mul_b = cfg.inv_depth_scale;
      end
      MUL_PX: begin
        mul_a = prod[39:8];
        mul_b = {8'b0, magx};
      end
      MUL_XH: begin
        mul_a = {8'b0, prod[47:24]};
        mul_b = cfg.inv_focal_x;
      end
      MUL_XL: begin
        mul_a = {8'b0, p[23:0]};
        mul_b = cfg.inv_focal_x;
      end
      MUL_PY: begin
        mul_a = z;
        mul_b = {8'b0, magy};
      end
      MUL_YH: begin
        mul_a = {8'b0, prod[47:24]};
        mul_b = cfg.inv_focal_y;
      end
      MUL_YL: begin
        mul_a = {8'b0, p[23:0]};
        mul_b = cfg.inv_focal_y;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum   = {acc, 24'b0} + {24'b0, prod[PART_W-1:0]};
  assign sum_r = sum[SUM_W-1:28];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    if (cmd.cap_z)   z   <= prod[39:8];
    if (cmd.cap_p)   p   <= prod[PART_W-1:0];
    if (cmd.cap_acc) acc <= prod[PART_W-1:0];
    if (cmd.cap_x)   x_q <= coord_sat(sum_r, negx);
    if (cmd.cap_y)   y_q <= coord_sat(sum_r, negy);
    if (cmd.load_out) out_data <= {red_q, green_q, blue_q, z, y_q, x_q};
  end

endmodule

// ===== rtl/core/depth_pixel_backprojection_unit.sv =====
// channel  | group   | tdata fields, lowest bits first
// ---------+---------+--------------------------------------------------------
// pixels   | s_axis  | depth_sample[15:0] blue[23:16] green[31:24] red[39:32]
// points   | m_axis  | point_x point_y point_z (32 each) out_blue out_green out_red
// config   | cfg_*   | write enable, register index, data
//
// a pixel off the subsample grid or with zero depth is dropped with the unit
// staying ready; a kept pixel reaches the output register after the seven passes
// through the single 32x24 multiplier (z, then |d|*z and two halves for x and y)
// reset restores the register defaults and clears column and row to zero
// a waiting result sits in the output register while the next pixel is taken;
// only a second kept pixel stalls, in its last step, until the first is taken
module depth_pixel_backprojection_unit
  import dpbu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // depth_sample, blue, green, red
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // point_x, point_y, point_z,
                                                 // out_blue, out_green, out_red
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  dpbu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpbu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  dpbu_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata)
  );

endmodule

// ===== rtl/core/dpbu_checker.sv =====
`include "depth_pixel_backprojection_unit_macros.svh"

module dpbu_checker
  import dpbu_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic zero_depth;

  assign zero_depth = (s_axis_tdata[DEPTH_W-1:0] == '0);

  // a stalled point stays up and unchanged
  `DPBU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `DPBU_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // a pixel with no depth is dropped and the input is ready again in the next cycle
  `DPBU_ASSERT_NEXT(a_drop_fast, s_axis_tvalid && s_axis_tready && zero_depth, s_axis_tready)

  // a new point only appears at the end of a busy sequence
  `DPBU_ASSERT_SAME(a_out_after_busy, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind depth_pixel_backprojection_unit dpbu_checker u_dpbu_checker (.*);
